// File: hdl/hsv2rgb_pkg.sv
// Shared types, constants and helpers for the HSV to RGB pixel converter.
// Depends on nothing; every module of the block imports it.
`default_nettype none

package hsv2rgb_pkg;

  // Field width of every channel: unsigned fixed point with 16 fraction bits.
  localparam int unsigned FW = 17;
  localparam int unsigned FRAC = 16;
  localparam logic [FW-1:0] ONE_Q16 = 17'h10000;

  // Depth of the queue between the front and the back part.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  // Sextant of the hue circle; codes six and seven take the default order.
  typedef enum logic [2:0] {
    SEXT_RED_YELLOW   = 3'd0,
    SEXT_YELLOW_GREEN = 3'd1,
    SEXT_GREEN_CYAN   = 3'd2,
    SEXT_CYAN_BLUE    = 3'd3,
    SEXT_BLUE_MAGENTA = 3'd4,
    SEXT_MAGENTA_RED  = 3'd5,
    SEXT_FULL_TURN    = 3'd6
  } sextant_e;

  // One classified pixel as it travels from the front to the back part.
  typedef struct packed {
    logic [FW-1:0] chroma;
    logic [FW-1:0] offset;
    logic [FW-1:0] weight;
    sextant_e      sextant;
  } item_t;

  // Queue status seen by the top level.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Saturates a field to the range 0.0 to 1.0.
  function automatic logic [FW-1:0] clamp_unit(input logic [FW-1:0] val);
    logic [FW-1:0] res;
    res = (val > ONE_Q16) ? ONE_Q16 : val;
    return res;
  endfunction

endpackage

`default_nettype wire

// File: hdl/hsv2rgb_front.sv
// Front part: clamps the inputs and classifies the pixel into chroma, offset,
// sextant and interpolation weight. Depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_front import hsv2rgb_pkg::*; (
  input  wire logic [FW-1:0] hue_i,
  input  wire logic [FW-1:0] saturation_i,
  input  wire logic [FW-1:0] brightness_i,
  output item_t              item_o
);

  logic [FW-1:0]     h_cl;
  logic [FW-1:0]     s_cl;
  logic [FW-1:0]     v_cl;
  logic [2*FW-1:0]   sv_prod;
  logic [FW-1:0]     chroma;
  logic [FW+2:0]     dh;
  logic [FW-1:0]     frac_two;
  logic [FW-1:0]     hue_dist;

  // Saturate every field to one before use.
  assign h_cl = clamp_unit(hue_i);
  assign s_cl = clamp_unit(saturation_i);
  assign v_cl = clamp_unit(brightness_i);

  // Chroma is the truncated product s*v; the offset is what remains of v.
  assign sv_prod = s_cl * v_cl;
  assign chroma  = sv_prod[FW+FRAC-1:FRAC];

  // Six times the hue, formed by shifts and one add.
  assign dh       = {1'b0, h_cl, 2'b00} + {2'b00, h_cl, 1'b0};
  assign frac_two = dh[FW-1:0];

  // Distance of the scaled hue from the middle of its sextant pair.
  assign hue_dist = (frac_two >= ONE_Q16) ? (frac_two - ONE_Q16) : (ONE_Q16 - frac_two);

  always_comb begin
    item_o.chroma  = chroma;
    item_o.offset  = v_cl - chroma;
    item_o.weight  = ONE_Q16 - hue_dist;
    item_o.sextant = sextant_e'(dh[FW+1:FRAC]);
  end

endmodule

`default_nettype wire

// File: hdl/hsv2rgb_queue.sv
// Short queue that decouples the front part from the back part.
// Depends on hsv2rgb_pkg for the item type and the depth.
`default_nettype none

module hsv2rgb_queue import hsv2rgb_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_valid_i,
  output logic       push_ready_o,
  input  wire item_t push_item_i,
  output logic       pop_valid_o,
  input  wire logic  pop_ready_i,
  output item_t      pop_item_o,
  output q_stat_t    stat_o
);

  item_t          entries_q [QDEPTH];
  logic [QAW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QAW:0]   count_q, count_d;
  logic           push, pop;

  assign push_ready_o = (count_q != (QAW+1)'(QDEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = entries_q[rd_ptr_q];
  assign stat_o.full  = !push_ready_o;
  assign stat_o.empty = !pop_valid_o;

  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  // Pointer and fill count updates; pointers wrap at the depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_q + QAW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_q + QAW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + (QAW+1)'(1);
    end else if (pop && !push) begin
      count_d = count_q - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

// File: hdl/hsv2rgb_back.sv
// Back part: forms the interpolated component, orders the channels by
// sextant and holds the result in an output register. Depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_back import hsv2rgb_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          item_valid_i,
  output logic               item_ready_o,
  input  wire item_t         item_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [FW-1:0]      red_o,
  output logic [FW-1:0]      green_o,
  output logic [FW-1:0]      blue_o
);

  logic            s1_valid_q;
  logic [FW-1:0]   x_q, chroma_q, offset_q;
  sextant_e        sextant_q;
  logic            out_valid_q;
  logic [FW-1:0]   red_q, green_q, blue_q;
  logic [FW-1:0]   red_d, green_d, blue_d;
  logic [2*FW-1:0] x_prod;
  logic [FW-1:0]   r_sel, g_sel, b_sel;
  logic            out_load, s1_load;

  // Each stage advances when the one after it is empty or being emptied.
  assign out_load     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign item_ready_o = !s1_valid_q || out_load;
  assign s1_load      = item_valid_i && item_ready_o;

  // Interpolated component x = chroma * weight, truncated.
  assign x_prod = item_i.chroma * item_i.weight;

  // Channel order by sextant; a full turn takes the default order.
  always_comb begin
    case (sextant_q)
      SEXT_RED_YELLOW: begin
        r_sel = chroma_q; g_sel = x_q;      b_sel = '0;
      end
      SEXT_YELLOW_GREEN: begin
        r_sel = x_q;      g_sel = chroma_q; b_sel = '0;
      end
      SEXT_GREEN_CYAN: begin
        r_sel = '0;       g_sel = chroma_q; b_sel = x_q;
      end
      SEXT_CYAN_BLUE: begin
        r_sel = '0;       g_sel = x_q;      b_sel = chroma_q;
      end
      SEXT_BLUE_MAGENTA: begin
        r_sel = x_q;      g_sel = '0;       b_sel = chroma_q;
      end
      SEXT_MAGENTA_RED: begin
        r_sel = chroma_q; g_sel = '0;       b_sel = x_q;
      end
      default: begin
        r_sel = chroma_q; g_sel = '0;       b_sel = '0;
      end
    endcase
    red_d   = r_sel + offset_q;
    green_d = g_sel + offset_q;
    blue_d  = b_sel + offset_q;
  end

  // Valid flags of both stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_q <= 1'b1;
      end else if (out_load) begin
        s1_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers of both stages.
  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      x_q       <= x_prod[FW+FRAC-1:FRAC];
      chroma_q  <= item_i.chroma;
      offset_q  <= item_i.offset;
      sextant_q <= item_i.sextant;
    end
    if (out_load) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

endmodule

`default_nettype wire

// File: hdl/hsv_to_rgb_pixel_top.sv
// HSV to RGB pixel converter, top level: front part, queue and back part.
// A result passes a queue entry, the stage-one and the output registers.
// Throughput: one pixel per cycle unless out_ready_i stalls the output; one pass
// through each of the two multipliers (chroma in front, interpolated x in back).
// Reset: rst_ni clears the queue and the stage flags; no pixel data is reset.
// Depends on hsv2rgb_pkg, hsv2rgb_front, hsv2rgb_queue and hsv2rgb_back.
`default_nettype none

module hsv_to_rgb_pixel_top import hsv2rgb_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [FW-1:0] hue_i,
  input  wire logic [FW-1:0] saturation_i,
  input  wire logic [FW-1:0] brightness_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [FW-1:0]      red_o,
  output logic [FW-1:0]      green_o,
  output logic [FW-1:0]      blue_o
);

  item_t   front_item;
  item_t   back_item;
  logic    back_valid;
  logic    back_ready;
  q_stat_t q_stat;

  // Classification of the incoming pixel.
  hsv2rgb_front u_front (
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .item_o       (front_item)
  );

  // Decoupling queue; a transaction on the input writes one entry.
  hsv2rgb_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_item_i  (front_item),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_item_o   (back_item),
    .stat_o       (q_stat)
  );

  // Channel computation and output register.
  hsv2rgb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (back_valid),
    .item_ready_o (back_ready),
    .item_i       (back_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o)
  );

`ifndef NO_ASSERTIONS
  // The queue can never be full and empty at once.
  a_queue_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  // Every shown channel stays within 0.0 to 1.0.
  a_channel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (red_o <= ONE_Q16) && (green_o <= ONE_Q16) && (blue_o <= ONE_Q16))
    else $error("output channel above one");

  // A pixel pushed into an empty queue is offered to the back part next cycle.
  a_queue_forward: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && q_stat.empty) |=> back_valid)
    else $error("queued pixel not offered to the back part");
`endif

endmodule

`default_nettype wire
